>>> design/pinhole_point_undistort_assert.svh
// assertion macros shared by the checker
`ifndef PINHOLE_POINT_UNDISTORT_ASSERT_SVH
`define PINHOLE_POINT_UNDISTORT_ASSERT_SVH

// expression holds on every clock edge out of reset
`define PUP_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define PUP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequent in the next cycle, checked also during reset
`define PUP_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/pup_pkg.sv
package pup_pkg;

    localparam int COORD_W         = 32;
    localparam int PIX_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int DEF_ITERATIONS  = 8;
    localparam int LIFT_STAGES     = 1;
    localparam int STAGES_PER_ITER = 6;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_INV_FOCAL_X   = 3'd0;
    localparam t_cfg_idx CFG_OFFSET_X      = 3'd1;
    localparam t_cfg_idx CFG_INV_FOCAL_Y   = 3'd2;
    localparam t_cfg_idx CFG_OFFSET_Y      = 3'd3;
    localparam t_cfg_idx CFG_RADIAL_K1     = 3'd4;
    localparam t_cfg_idx CFG_RADIAL_K2     = 3'd5;
    localparam t_cfg_idx CFG_TANGENTIAL_P1 = 3'd6;
    localparam t_cfg_idx CFG_TANGENTIAL_P2 = 3'd7;

    localparam logic [31:0] INV_FOCAL_RESET = 32'h8000_0000;

    localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = 48'shFFFF_8000_0000;

    typedef struct packed {
        logic               valid;
        logic               clip;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] xd;
        logic signed [31:0] yd;
    } t_point;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_coef;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } t_qval;

    function automatic logic signed [47:0] sx48(input logic signed [31:0] a);
        return 48'(a);
    endfunction

    // clamp to the signed 32-bit range
    function automatic t_qval sat48(input logic signed [47:0] v);
        t_qval r;
        if (v > SAT_MAX) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

    // q4.28 product, round half up, saturate
    function automatic t_qval qmul(input logic signed [31:0] a,
                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = a * b;
        r = (p + 64'sd134217728) >>> 28;
        return sat48(r[47:0]);
    endfunction

endpackage

>>> design/pup_lift.sv
module pup_lift
    import pup_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [PIX_W-1:0]          i_pixel_u,
    input  logic [PIX_W-1:0]          i_pixel_v,
    input  logic [31:0]               i_inv_focal_x,
    input  logic [31:0]               i_inv_focal_y,
    input  logic signed [31:0]        i_offset_x,
    input  logic signed [31:0]        i_offset_y,
    output t_point                    o_pt
);

    logic [47:0]        w_prod_x, w_prod_y;
    logic [47:0]        w_rnd_x, w_rnd_y;
    logic signed [47:0] w_sum_x, w_sum_y;
    t_qval              w_qx, w_qy;
    t_point             n_pt, r_pt;

    always_comb begin
        w_prod_x = 48'(i_inv_focal_x) * 48'(i_pixel_u);
        w_prod_y = 48'(i_inv_focal_y) * 48'(i_pixel_v);
        w_rnd_x  = w_prod_x + 48'd64;
        w_rnd_y  = w_prod_y + 48'd64;
        w_sum_x  = $signed({7'b0, w_rnd_x[47:7]}) + sx48(i_offset_x);
        w_sum_y  = $signed({7'b0, w_rnd_y[47:7]}) + sx48(i_offset_y);
        w_qx     = sat48(w_sum_x);
        w_qy     = sat48(w_sum_y);
        n_pt.valid = i_start;
        n_pt.clip  = w_qx.clip | w_qy.clip;
        n_pt.x     = w_qx.val;
        n_pt.y     = w_qy.val;
        n_pt.xd    = w_qx.val;
        n_pt.yd    = w_qy.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt <= '0;
        end else begin
            r_pt <= n_pt;
        end
    end

    assign o_pt = r_pt;

endmodule

>>> design/pup_iter.sv
module pup_iter
    import pup_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_coef  i_coef,
    input  t_point i_pt,
    output t_point o_pt
);

    // stage 1: squares and cross term
    t_point             r1_pt;
    logic signed [31:0] r1_x2, r1_y2, r1_xy;
    // stage 2: radius and tangential sums
    t_point             r2_pt;
    logic signed [31:0] r2_r2, r2_tx, r2_ty, r2_xy;
    // stage 3: coefficient products
    t_point             r3_pt;
    logic signed [31:0] r3_r4, r3_k1r2, r3_p1xy, r3_p2xy, r3_p2tx, r3_p1ty;
    // stage 4: radial factor
    t_point             r4_pt;
    logic signed [31:0] r4_rad, r4_p1xy, r4_p2xy, r4_p2tx, r4_p1ty;
    // stage 5: radial terms
    t_point             r5_pt;
    logic signed [31:0] r5_xrad, r5_yrad, r5_p1xy, r5_p2xy, r5_p2tx, r5_p1ty;
    // stage 6: new estimate
    t_point             r6_pt;

    t_point n1_pt, n2_pt, n3_pt, n4_pt, n5_pt, n6_pt;

    t_qval q1_x2, q1_y2, q1_xy;
    t_qval q2_r2, q2_tx, q2_ty;
    t_qval q3_r4, q3_k1r2, q3_p1xy, q3_p2xy, q3_p2tx, q3_p1ty;
    t_qval q4_k2r4, q4_rad;
    t_qval q5_xrad, q5_yrad;
    t_qval q6_dx, q6_dy, q6_xu, q6_yu;

    always_comb begin
        q1_x2 = qmul(i_pt.x, i_pt.x);
        q1_y2 = qmul(i_pt.y, i_pt.y);
        q1_xy = qmul(i_pt.x, i_pt.y);

        q2_r2 = sat48(sx48(r1_x2) + sx48(r1_y2));
        q2_tx = sat48(sx48(q2_r2.val) + (sx48(r1_x2) <<< 1));
        q2_ty = sat48(sx48(q2_r2.val) + (sx48(r1_y2) <<< 1));

        q3_r4   = qmul(r2_r2, r2_r2);
        q3_k1r2 = qmul(i_coef.k1, r2_r2);
        q3_p1xy = qmul(i_coef.p1, r2_xy);
        q3_p2xy = qmul(i_coef.p2, r2_xy);
        q3_p2tx = qmul(i_coef.p2, r2_tx);
        q3_p1ty = qmul(i_coef.p1, r2_ty);

        q4_k2r4 = qmul(i_coef.k2, r3_r4);
        q4_rad  = sat48(sx48(r3_k1r2) + sx48(q4_k2r4.val));

        q5_xrad = qmul(r4_pt.x, r4_rad);
        q5_yrad = qmul(r4_pt.y, r4_rad);

        q6_dx = sat48(sx48(r5_xrad) + (sx48(r5_p1xy) <<< 1) + sx48(r5_p2tx));
        q6_dy = sat48(sx48(r5_yrad) + (sx48(r5_p2xy) <<< 1) + sx48(r5_p1ty));
        q6_xu = sat48(sx48(r5_pt.xd) - sx48(q6_dx.val));
        q6_yu = sat48(sx48(r5_pt.yd) - sx48(q6_dy.val));

        n1_pt      = i_pt;
        n1_pt.clip = i_pt.clip | q1_x2.clip | q1_y2.clip | q1_xy.clip;
        n2_pt      = r1_pt;
        n2_pt.clip = r1_pt.clip | q2_r2.clip | q2_tx.clip | q2_ty.clip;
        n3_pt      = r2_pt;
        n3_pt.clip = r2_pt.clip | q3_r4.clip | q3_k1r2.clip | q3_p1xy.clip
                     | q3_p2xy.clip | q3_p2tx.clip | q3_p1ty.clip;
        n4_pt      = r3_pt;
        n4_pt.clip = r3_pt.clip | q4_k2r4.clip | q4_rad.clip;
        n5_pt      = r4_pt;
        n5_pt.clip = r4_pt.clip | q5_xrad.clip | q5_yrad.clip;
        n6_pt      = r5_pt;
        n6_pt.clip = r5_pt.clip | q6_dx.clip | q6_dy.clip | q6_xu.clip | q6_yu.clip;
        n6_pt.x    = q6_xu.val;
        n6_pt.y    = q6_yu.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_pt <= '0;
            r2_pt <= '0;
            r3_pt <= '0;
            r4_pt <= '0;
            r5_pt <= '0;
            r6_pt <= '0;
        end else begin
            r1_pt <= n1_pt;
            r2_pt <= n2_pt;
            r3_pt <= n3_pt;
            r4_pt <= n4_pt;
            r5_pt <= n5_pt;
            r6_pt <= n6_pt;
        end

        r1_x2      <= q1_x2.val;
        r1_y2      <= q1_y2.val;
        r1_xy      <= q1_xy.val;

        r2_r2      <= q2_r2.val;
        r2_tx      <= q2_tx.val;
        r2_ty      <= q2_ty.val;
        r2_xy      <= r1_xy;

        r3_r4      <= q3_r4.val;
        r3_k1r2    <= q3_k1r2.val;
        r3_p1xy    <= q3_p1xy.val;
        r3_p2xy    <= q3_p2xy.val;
        r3_p2tx    <= q3_p2tx.val;
        r3_p1ty    <= q3_p1ty.val;

        r4_rad     <= q4_rad.val;
        r4_p1xy    <= r3_p1xy;
        r4_p2xy    <= r3_p2xy;
        r4_p2tx    <= r3_p2tx;
        r4_p1ty    <= r3_p1ty;

        r5_xrad    <= q5_xrad.val;
        r5_yrad    <= q5_yrad.val;
        r5_p1xy    <= r4_p1xy;
        r5_p2xy    <= r4_p2xy;
        r5_p2tx    <= r4_p2tx;
        r5_p1ty    <= r4_p1ty;
    end

    assign o_pt = r6_pt;

endmodule

>>> design/pinhole_point_undistort.sv
// from the accepting edge to o_valid, a word passes the lift stage, then every stage of each unrolled iteration
// throughput: one word per cycle, o_busy stays low; set by the fully unrolled iteration chain
// results are strobed by o_valid for one cycle and cannot be held off
// reset: synchronous active low, clears all stage valid bits and loads default registers
module pinhole_point_undistort
    import pup_pkg::*;
#(
    parameter int ITERATIONS = DEF_ITERATIONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    // input word
    input  logic                i_start,
    output logic                o_busy,
    input  logic [PIX_W-1:0]    i_pixel_u,
    input  logic [PIX_W-1:0]    i_pixel_v,
    // result word
    output logic                o_valid,
    output logic signed [31:0]  o_norm_x,
    output logic signed [31:0]  o_norm_y,
    output logic                o_clipped
);

    // intrinsics and distortion coefficients
    logic [31:0]        r_inv_focal_x, r_inv_focal_y;
    logic signed [31:0] r_offset_x, r_offset_y;
    t_coef              r_coef;

    // point state between iterations, index 0 is the lifted point
    t_point w_pt [ITERATIONS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_focal_x <= INV_FOCAL_RESET;
            r_inv_focal_y <= INV_FOCAL_RESET;
            r_offset_x    <= '0;
            r_offset_y    <= '0;
            r_coef        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_FOCAL_X:   r_inv_focal_x <= i_cfg_data;
                CFG_OFFSET_X:      r_offset_x    <= i_cfg_data;
                CFG_INV_FOCAL_Y:   r_inv_focal_y <= i_cfg_data;
                CFG_OFFSET_Y:      r_offset_y    <= i_cfg_data;
                CFG_RADIAL_K1:     r_coef.k1     <= i_cfg_data;
                CFG_RADIAL_K2:     r_coef.k2     <= i_cfg_data;
                CFG_TANGENTIAL_P1: r_coef.p1     <= i_cfg_data;
                CFG_TANGENTIAL_P2: r_coef.p2     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pixel to normalized plane, one stage
    pup_lift u_lift (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_pixel_u     (i_pixel_u),
        .i_pixel_v     (i_pixel_v),
        .i_inv_focal_x (r_inv_focal_x),
        .i_inv_focal_y (r_inv_focal_y),
        .i_offset_x    (r_offset_x),
        .i_offset_y    (r_offset_y),
        .o_pt          (w_pt[0])
    );

    // unrolled fixed-point iterations, six stages each
    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        pup_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (r_coef),
            .i_pt    (w_pt[g]),
            .o_pt    (w_pt[g+1])
        );
    end

    // pipeline never stalls
    assign o_busy    = 1'b0;
    assign o_valid   = w_pt[ITERATIONS].valid;
    assign o_norm_x  = w_pt[ITERATIONS].x;
    assign o_norm_y  = w_pt[ITERATIONS].y;
    assign o_clipped = w_pt[ITERATIONS].clip;

endmodule

>>> design/pup_checker.sv
`include "pinhole_point_undistort_assert.svh"

module pup_checker
    import pup_pkg::*;
#(
    parameter int LATENCY = LIFT_STAGES + STAGES_PER_ITER * DEF_ITERATIONS
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // the pipeline always takes a word
    `PUP_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !o_busy)
    // every result traces back to a start, delayed by the lift stage and all iteration stages
    `PUP_ASSERT_IMPL(a_valid_from_start, i_clk, i_rst_n, o_valid, $past(i_start, LATENCY))
    // reset empties the output stage
    `PUP_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, !o_valid)

endmodule

bind pinhole_point_undistort pup_checker #(
    .LATENCY(LIFT_STAGES + STAGES_PER_ITER * ITERATIONS)
) u_pup_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);

>>> bench/tb_pinhole_point_undistort.sv
`timescale 1ns / 1ps

module tb_pinhole_point_undistort;
    import pup_pkg::*;

    localparam int ITERS   = DEF_ITERATIONS;
    // accepting edge to o_valid, plus a small margin
    localparam int LATENCY = LIFT_STAGES + STAGES_PER_ITER * DEF_ITERATIONS;
    localparam int SETTLE  = LATENCY + 8;
    localparam int RAND_PER_PHASE = 230;

    typedef struct {
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
    } t_pixel;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               clip;
    } t_ray;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;
    logic                 i_start;
    logic                 o_busy;
    logic [PIX_W-1:0]     i_pixel_u;
    logic [PIX_W-1:0]     i_pixel_v;
    logic                 o_valid;
    logic signed [31:0]   o_norm_x;
    logic signed [31:0]   o_norm_y;
    logic                 o_clipped;

    pinhole_point_undistort dut (.*);

    // clock, 8 ns period
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // shadow copy of the camera registers, updated on every write
    logic [31:0] cam_reg [8];

    t_pixel pixels_pending [$];   // words waiting for the driver
    t_ray   rays_expected [$];    // undistorted points still to come out

    int  mismatches;
    int  words_taken;
    int  rays_seen;
    int  clipped_seen;
    int  idle_pct;                // chance of an idle burst per word, in percent
    int  gap_left;
    logic took;                   // word on the pins was taken at the last rising edge

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h (ray %0d)", what, got, want, rays_seen);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // predictor: signed 32-bit fixed point held in 64-bit longints
    // ---------------------------------------------------------------
    function automatic longint clamp32(input longint v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // q4.28 times q4.28, round half up, clamp
    function automatic longint qprod(input longint a, input longint b, inout bit hit);
        longint p;
        p = a * b;
        return clamp32((p + (64'sd1 <<< 27)) >>> 28, hit);
    endfunction

    // pixel to normalised plane: q1.31 * q12.4 rounded half up to .28 plus offset
    function automatic longint lift_axis(input logic [31:0] inv_f, input logic [15:0] pix,
                                         input logic [31:0] off, inout bit hit);
        longint p;
        p = longint'({32'd0, inv_f}) * longint'({48'd0, pix});
        return clamp32(((p + 64) >>> 7) + longint'(signed'(off)), hit);
    endfunction

    function automatic t_ray undistort_point(input t_pixel px);
        t_ray   r;
        bit     hit;
        longint k1, k2, p1, p2;
        longint xd, yd, xu, yu;
        longint x2, y2, xy, r2, r4, rad, tx, ty, dx, dy;
        hit = 1'b0;
        k1 = longint'(signed'(cam_reg[CFG_RADIAL_K1]));
        k2 = longint'(signed'(cam_reg[CFG_RADIAL_K2]));
        p1 = longint'(signed'(cam_reg[CFG_TANGENTIAL_P1]));
        p2 = longint'(signed'(cam_reg[CFG_TANGENTIAL_P2]));
        xd = lift_axis(cam_reg[CFG_INV_FOCAL_X], px.u, cam_reg[CFG_OFFSET_X], hit);
        yd = lift_axis(cam_reg[CFG_INV_FOCAL_Y], px.v, cam_reg[CFG_OFFSET_Y], hit);
        xu = xd;
        yu = yd;
        // fixed-point iteration u = d - distortion(u)
        for (int i = 0; i < ITERS; i++) begin
            x2  = qprod(xu, xu, hit);
            y2  = qprod(yu, yu, hit);
            xy  = qprod(xu, yu, hit);
            r2  = clamp32(x2 + y2, hit);
            r4  = qprod(r2, r2, hit);
            rad = clamp32(qprod(k1, r2, hit) + qprod(k2, r4, hit), hit);
            tx  = clamp32(r2 + 2 * x2, hit);
            ty  = clamp32(r2 + 2 * y2, hit);
            dx  = clamp32(qprod(xu, rad, hit) + 2 * qprod(p1, xy, hit)
                          + qprod(p2, tx, hit), hit);
            dy  = clamp32(qprod(yu, rad, hit) + 2 * qprod(p2, xy, hit)
                          + qprod(p1, ty, hit), hit);
            xu  = clamp32(xd - dx, hit);
            yu  = clamp32(yd - dy, hit);
        end
        r.x    = xu[31:0];
        r.y    = yu[31:0];
        r.clip = hit;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // driver: one word per start, idle bursts between words
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_pixel px;
        if (i_rst_n && !(i_start && !took)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (pixels_pending.size() > 0) begin
                if ($urandom_range(99, 0) < idle_pct) begin
                    // start an idle burst, this cycle included
                    gap_left = $urandom_range(12, 1) - 1;
                    i_start <= 1'b0;
                end else begin
                    px = pixels_pending.pop_front();
                    i_start   <= 1'b1;
                    i_pixel_u <= px.u;
                    i_pixel_v <= px.v;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: predict on acceptance, compare each strobed result
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel px;
        t_ray   want;
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            took <= i_start && !o_busy;
            if (i_start && !o_busy) begin
                px.u = i_pixel_u;
                px.v = i_pixel_v;
                rays_expected.push_back(undistort_point(px));
                words_taken++;
            end
            if (o_valid) begin
                rays_seen++;
                if (o_clipped) clipped_seen++;
                if (rays_expected.size() == 0) begin
                    report("unexpected ray", o_norm_x, 0);
                end else begin
                    want = rays_expected.pop_front();
                    if (o_norm_x !== want.x) report("norm_x", o_norm_x, want.x);
                    if (o_norm_y !== want.y) report("norm_y", o_norm_y, want.y);
                    if (o_clipped !== want.clip) report("clipped", o_clipped, want.clip);
                end
            end
        end
    end

    // register write, only while the pipe is empty
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        cam_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_camera(input logic [31:0] ifx, input logic [31:0] ox,
                               input logic [31:0] ify, input logic [31:0] oy,
                               input logic [31:0] k1, input logic [31:0] k2,
                               input logic [31:0] p1, input logic [31:0] p2);
        write_reg(CFG_INV_FOCAL_X, ifx);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_INV_FOCAL_Y, ify);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_RADIAL_K1, k1);
        write_reg(CFG_RADIAL_K2, k2);
        write_reg(CFG_TANGENTIAL_P1, p1);
        write_reg(CFG_TANGENTIAL_P2, p2);
    endtask

    // a plausible lens: focal length a few hundred pixels, mild distortion
    task automatic load_real_lens();
        load_camera($urandom_range(12_000_000, 2_000_000),
                    -$urandom_range(32'd400_000_000, 32'd0),
                    $urandom_range(12_000_000, 2_000_000),
                    -$urandom_range(32'd400_000_000, 32'd0),
                    $urandom_range(32'd100_000_000, 32'd0) - 32'd50_000_000,
                    $urandom_range(32'd40_000_000, 32'd0) - 32'd20_000_000,
                    $urandom_range(32'd1_000_000, 32'd0) - 32'd500_000,
                    $urandom_range(32'd1_000_000, 32'd0) - 32'd500_000);
    endtask

    task automatic queue_pixel(input logic [15:0] u, input logic [15:0] v);
        t_pixel px;
        px.u = u;
        px.v = v;
        pixels_pending.push_back(px);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) queue_pixel($urandom, $urandom);
    endtask

    // hold off until every word is in and every ray is out, then let the pipe drain
    task automatic drain();
        do @(negedge i_clk);
        while (pixels_pending.size() > 0 || i_start || rays_expected.size() > 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_INV_FOCAL_X;
        i_cfg_data = '0;
        i_start    = 1'b0;
        i_pixel_u  = '0;
        i_pixel_v  = '0;
        took       = 1'b0;
        gap_left   = 0;
        idle_pct   = 0;
        mismatches = 0;
        words_taken = 0;
        rays_seen   = 0;
        clipped_seen = 0;
        cam_reg[CFG_INV_FOCAL_X]   = INV_FOCAL_RESET;
        cam_reg[CFG_OFFSET_X]      = '0;
        cam_reg[CFG_INV_FOCAL_Y]   = INV_FOCAL_RESET;
        cam_reg[CFG_OFFSET_Y]      = '0;
        cam_reg[CFG_RADIAL_K1]     = '0;
        cam_reg[CFG_RADIAL_K2]     = '0;
        cam_reg[CFG_TANGENTIAL_P1] = '0;
        cam_reg[CFG_TANGENTIAL_P2] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset registers: identity lift, zero coefficients
        queue_pixel(16'h0000, 16'h0000);
        queue_pixel(16'hFFFF, 16'hFFFF);
        queue_pixel(16'hFFFF, 16'h0000);
        queue_pixel(16'h0000, 16'hFFFF);
        queue_pixel(16'h0001, 16'h8000);
        queue_pixel(16'h5555, 16'hAAAA);
        drain();

        // zero focal and offset extremes: lift saturates upward and reaches the signed minimum
        load_camera(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_pixel(16'h0000, 16'h0000);
        queue_pixel(16'hFFFF, 16'hFFFF);
        queue_pixel(16'h0010, 16'h0010);
        drain();
        load_camera(32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_pixel(16'h0000, 16'h0000);
        queue_pixel(16'hFFFF, 16'hFFFF);
        queue_pixel(16'h1234, 16'h0001);
        drain();

        // small points near the center with strong distortion, no clipping expected
        load_camera(32'h0001_0000, 32'hF800_0000, 32'h0001_0000, 32'h0800_0000,
                    32'hFB00_0000, 32'h0100_0000, 32'h0010_0000, 32'hFFF0_0000);
        queue_pixel(16'h0000, 16'h0000);
        queue_pixel(16'h8000, 16'h8000);
        queue_pixel(16'hFFFF, 16'h0000);
        queue_pixel(16'h0000, 16'hFFFF);
        drain();

        // random part: real lenses mostly, a few arbitrary register sets
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2 || ph == 4)
                load_camera($urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom);
            else
                load_real_lens();
            // one phase without idling, the last one as well
            idle_pct = (ph == 3 || ph == 5) ? 0 : $urandom_range(30, 5);
            queue_random(RAND_PER_PHASE);
            drain();
        end

        $display("covered %0d points, %0d rays checked, %0d clipped",
                 words_taken, rays_seen, clipped_seen);
        $display("register extremes, reset, plausible and arbitrary lenses, idle bursts");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
